// ===== hw/rtl/tournament_branch_predictor_macros.svh =====
// ----------------------------------------------------------------------------
// Tournament branch predictor assertion macros
// Clocked assertion helpers; compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define TBP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`define TBP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define TBP_ASSERT_NEVER(label, cond, msg)
`define TBP_ASSERT_IMPLY(label, ante, cons, msg)
`define TBP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, constants and counter helper for the tournament predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned ADDR_LSB = 2;
    localparam int unsigned TOTAL_W  = 32;

    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_MIN   = 2'd0;
    localparam t_ctr CTR_MAX   = 2'd3;
    localparam t_ctr CTR_RESET = 2'd2;   // weakly taken
    localparam t_ctr CHO_RESET = 2'd1;   // weakly bimodal

    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    localparam int unsigned OUTQ_DEPTH = 4;
    localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic               predicted_taken;
        logic               mispredicted;
        logic               used_gshare;
        logic [TOTAL_W-1:0] mispredict_total;
    } t_result;

    // 2-bit saturating counter step
    function automatic t_ctr ctr_train(t_ctr c, logic up);
        t_ctr r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/tbp_in_if.sv =====
// ----------------------------------------------------------------------------
// tbp_in_if
// Resolved-branch channel: valid/ready with address and outcome.
// ----------------------------------------------------------------------------
interface tbp_in_if;
    import tbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] branch_address;
    logic              taken;

    modport source (output valid, output branch_address, output taken, input ready);
    modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

// ===== hw/rtl/tbp_out_if.sv =====
// ----------------------------------------------------------------------------
// tbp_out_if
// Prediction result channel: valid/ready with prediction and miss count.
// ----------------------------------------------------------------------------
interface tbp_out_if;
    import tbp_pkg::*;

    logic               valid;
    logic               ready;
    logic               predicted_taken;
    logic               mispredicted;
    logic               used_gshare;
    logic [TOTAL_W-1:0] mispredict_total;

    modport source (output valid, output predicted_taken, output mispredicted,
                    output used_gshare, output mispredict_total, input ready);
    modport sink   (input valid, input predicted_taken, input mispredicted,
                    input used_gshare, input mispredict_total, output ready);
endinterface

// ===== hw/rtl/tbp_ram.sv =====
// ----------------------------------------------------------------------------
// tbp_ram
// Simple dual-port RAM, one write and one registered read (read-old).
// ----------------------------------------------------------------------------
module tbp_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/tbp_out_queue.sv =====
// ----------------------------------------------------------------------------
// tbp_out_queue
// Small result FIFO decoupling the predictor pipe from the result sink.
// ----------------------------------------------------------------------------
module tbp_out_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  tbp_pkg::t_result          i_word,
    output logic [tbp_pkg::OUTQ_CNT_W-1:0] o_count,
    tbp_out_if.source                 o_res
);
    import tbp_pkg::*;

    t_result                r_entry [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wptr;
    logic [OUTQ_PTR_W-1:0]  r_rptr;
    logic [OUTQ_CNT_W-1:0]  r_count;
    logic [OUTQ_CNT_W-1:0]  n_count;
    logic                   pop;
    t_result                head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_entry[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) n_count = r_count + OUTQ_CNT_W'(1);
        if (!i_push && pop) n_count = r_count - OUTQ_CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + OUTQ_PTR_W'(1);
            if (pop)    r_rptr <= r_rptr + OUTQ_PTR_W'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_word;
        end
    end

    assign o_count                = r_count;
    assign o_res.valid            = (r_count != '0);
    assign o_res.predicted_taken  = head.predicted_taken;
    assign o_res.mispredicted     = head.mispredicted;
    assign o_res.used_gshare      = head.used_gshare;
    assign o_res.mispredict_total = head.mispredict_total;
endmodule

// ===== hw/rtl/tournament_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Bimodal + gshare predictor with a per-address chooser, trained in place.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake   | word
//  ---------+-----+-------------+------------------------------------------
//  i_br     | in  | valid/ready | branch_address[31:0], taken
//  o_res    | out | valid/ready | predicted_taken, mispredicted,
//           |     |             | used_gshare, mispredict_total[31:0]
//  i_cfg_*  | in  | write only  | i_cfg_data[1:0] -> predictor_mode
//
//  One word per cycle sustained while the result queue has room and no
//  clearing pass runs. An accepted word reads the three tables through
//  registered read ports, is predicted and trained in the next cycle and
//  reaches o_res through a 4-entry result queue. After reset a clearing pass
//  writes the table reset values, one entry per cycle, over 2**max(index
//  bits) entries (1024 at defaults), with i_br.ready low. Otherwise ready
//  drops only when the queue plus the word in flight would exceed its depth.
// ----------------------------------------------------------------------------
`include "tournament_branch_predictor_macros.svh"

module tournament_branch_predictor #(
    parameter int unsigned BIMODAL_INDEX_BITS = 10,
    parameter int unsigned GSHARE_INDEX_BITS  = 10,
    parameter int unsigned HISTORY_BITS       = 8,
    parameter int unsigned CHOOSER_INDEX_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbp_in_if.sink     i_br,
    tbp_out_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);
    import tbp_pkg::*;

    localparam int unsigned BW = BIMODAL_INDEX_BITS;
    localparam int unsigned GW = GSHARE_INDEX_BITS;
    localparam int unsigned HW = HISTORY_BITS;
    localparam int unsigned CW = CHOOSER_INDEX_BITS;
    localparam int unsigned BG_MAX = (BW > GW) ? BW : GW;
    localparam int unsigned CLR_W  = (BG_MAX > CW) ? BG_MAX : CW;

    // ---------------- control / config ----------------
    logic [1:0]         r_mode;
    logic               r_clr;          // clearing pass in progress
    logic [CLR_W-1:0]   r_clr_idx;
    logic [HW-1:0]      r_hist;
    logic [HW:0]        n_hist_wide;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               r_s1_valid;     // word in the predict/train stage

    logic accept;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HYBRID;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // room for the word in flight plus a new one
    assign i_br.ready = !r_clr &&
                        ((OUTQ_CNT_W'(r_s1_valid) + q_count) < OUTQ_CNT_W'(OUTQ_DEPTH));
    assign accept = i_br.valid && i_br.ready;
    assign q_full = (q_count == OUTQ_CNT_W'(OUTQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_clr) begin
            r_clr_idx <= r_clr_idx + CLR_W'(1);
            if (r_clr_idx == '1) r_clr <= 1'b0;
        end
    end

    // ---------------- stage 0: index and history ----------------
    logic [GW+HW-1:0] hist_wide;
    logic [GW-1:0]    gmix;
    logic [BW-1:0]    bidx_in;
    logic [GW-1:0]    gidx_in;
    logic [CW-1:0]    cidx_in;

    // top GW bits of {history, zeros}: left-aligns short history,
    // drops low bits of a long one
    assign hist_wide = {r_hist, {GW{1'b0}}};
    assign gmix      = hist_wide[GW+HW-1 -: GW];
    assign bidx_in   = i_br.branch_address[ADDR_LSB +: BW];
    assign gidx_in   = i_br.branch_address[ADDR_LSB +: GW] ^ gmix;
    assign cidx_in   = i_br.branch_address[ADDR_LSB +: CW];

    assign n_hist_wide = {i_br.taken, r_hist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (accept) begin
            r_hist <= n_hist_wide[HW:1];
        end
    end

    // ---------------- stage 1 registers ----------------
    logic          r_s1_taken;
    logic [BW-1:0] r_s1_bidx;
    logic [GW-1:0] r_s1_gidx;
    logic [CW-1:0] r_s1_cidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_taken <= i_br.taken;
            r_s1_bidx  <= bidx_in;
            r_s1_gidx  <= gidx_in;
            r_s1_cidx  <= cidx_in;
        end
    end

    // ---------------- tables ----------------
    t_ctr          bim_rdata, gsh_rdata, cho_rdata;
    logic          bim_we, gsh_we, cho_we;
    logic [BW-1:0] bim_waddr;
    logic [GW-1:0] gsh_waddr;
    logic [CW-1:0] cho_waddr;
    t_ctr          bim_wdata, gsh_wdata, cho_wdata;

    tbp_ram #(.WIDTH(2), .DEPTH(2 ** BW)) u_bim_ram (
        .i_clk   (i_clk),
        .i_we    (bim_we),
        .i_waddr (bim_waddr),
        .i_wdata (bim_wdata),
        .i_raddr (bidx_in),
        .o_rdata (bim_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2 ** GW)) u_gsh_ram (
        .i_clk   (i_clk),
        .i_we    (gsh_we),
        .i_waddr (gsh_waddr),
        .i_wdata (gsh_wdata),
        .i_raddr (gidx_in),
        .o_rdata (gsh_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2 ** CW)) u_cho_ram (
        .i_clk   (i_clk),
        .i_we    (cho_we),
        .i_waddr (cho_waddr),
        .i_wdata (cho_wdata),
        .i_raddr (cidx_in),
        .o_rdata (cho_rdata)
    );

    // ---------------- forwarding of last cycle's writes ----------------
    // The RAM returns the old value when a word reads an entry that the
    // previous word writes in the same cycle; these registers patch that.
    logic          r_bfw_valid, r_gfw_valid, r_cfw_valid;
    logic [BW-1:0] r_bfw_addr;
    logic [GW-1:0] r_gfw_addr;
    logic [CW-1:0] r_cfw_addr;
    t_ctr          r_bfw_data, r_gfw_data, r_cfw_data;

    t_ctr bc, gc, cc;
    assign bc = (r_bfw_valid && r_bfw_addr == r_s1_bidx) ? r_bfw_data : bim_rdata;
    assign gc = (r_gfw_valid && r_gfw_addr == r_s1_gidx) ? r_gfw_data : gsh_rdata;
    assign cc = (r_cfw_valid && r_cfw_addr == r_s1_cidx) ? r_cfw_data : cho_rdata;

    // ---------------- stage 1: predict and train ----------------
    logic pb, pg, use_g, hybrid, pred, miss;
    logic s1_bim_we, s1_gsh_we, s1_cho_we;
    t_ctr bim_new, gsh_new, cho_new;

    assign pb = bc[1];
    assign pg = gc[1];

    always_comb begin
        case (r_mode)
            MODE_BIMODAL: begin
                use_g  = 1'b0;
                hybrid = 1'b0;
            end
            MODE_GSHARE: begin
                use_g  = 1'b1;
                hybrid = 1'b0;
            end
            default: begin                // hybrid, unused code too
                use_g  = cc[1];
                hybrid = 1'b1;
            end
        endcase
    end

    assign pred = use_g ? pg : pb;
    assign miss = (pred != r_s1_taken);

    assign bim_new = ctr_train(bc, r_s1_taken);
    assign gsh_new = ctr_train(gc, r_s1_taken);

    // chooser moves toward the component that alone was right
    always_comb begin
        cho_new = cc;
        if (pb == r_s1_taken && pg != r_s1_taken) cho_new = ctr_train(cc, 1'b0);
        if (pb != r_s1_taken && pg == r_s1_taken) cho_new = ctr_train(cc, 1'b1);
    end

    assign s1_bim_we = r_s1_valid && !use_g;
    assign s1_gsh_we = r_s1_valid && use_g;
    assign s1_cho_we = r_s1_valid && hybrid;

    // write ports: clearing pass, else training
    assign bim_we    = r_clr ? (CLR_W'(r_clr_idx >> BW) == '0) : s1_bim_we;
    assign bim_waddr = r_clr ? r_clr_idx[BW-1:0] : r_s1_bidx;
    assign bim_wdata = r_clr ? CTR_RESET : bim_new;
    assign gsh_we    = r_clr ? (CLR_W'(r_clr_idx >> GW) == '0) : s1_gsh_we;
    assign gsh_waddr = r_clr ? r_clr_idx[GW-1:0] : r_s1_gidx;
    assign gsh_wdata = r_clr ? CTR_RESET : gsh_new;
    assign cho_we    = r_clr ? (CLR_W'(r_clr_idx >> CW) == '0) : s1_cho_we;
    assign cho_waddr = r_clr ? r_clr_idx[CW-1:0] : r_s1_cidx;
    assign cho_wdata = r_clr ? CHO_RESET : cho_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bfw_valid <= 1'b0;
            r_gfw_valid <= 1'b0;
            r_cfw_valid <= 1'b0;
        end else begin
            r_bfw_valid <= s1_bim_we;
            r_gfw_valid <= s1_gsh_we;
            r_cfw_valid <= s1_cho_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bfw_addr <= r_s1_bidx;
        r_bfw_data <= bim_new;
        r_gfw_addr <= r_s1_gidx;
        r_gfw_data <= gsh_new;
        r_cfw_addr <= r_s1_cidx;
        r_cfw_data <= cho_new;
    end

    // ---------------- miss counter (saturating) ----------------
    always_comb begin
        n_total = r_total;
        if (r_s1_valid && miss && r_total != '1) n_total = r_total + TOTAL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            r_total <= n_total;
        end
    end

    // ---------------- result queue ----------------
    t_result s1_word;
    assign s1_word.predicted_taken  = pred;
    assign s1_word.mispredicted     = miss;
    assign s1_word.used_gshare      = use_g;
    assign s1_word.mispredict_total = n_total;

    tbp_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_word  (s1_word),
        .o_count (q_count),
        .o_res   (o_res)
    );

    // ---------------- assertions ----------------
    `TBP_ASSERT_NEVER(a_q_no_overflow, r_s1_valid && q_full, "result queue overflow")
    `TBP_ASSERT_IMPLY(a_no_word_in_clear, r_s1_valid, !$past(r_clr), "word during clearing")
    `TBP_ASSERT_NEXT(a_total_monotonic, 1'b1, r_total >= $past(r_total), "miss count went down")
endmodule

// ===== verif/tournament_branch_predictor_test.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor_test
// Drives resolved branches into the predictor under random sender bursts and
// receiver stalls, and checks each result word against a cycle-free model of
// the bimodal / gshare / chooser tables, across all predictor modes.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_test;
    import tbp_pkg::*;

    // Table geometry, matching the block's default parameters
    localparam int unsigned BIM_BITS  = 10;
    localparam int unsigned GSH_BITS  = 10;
    localparam int unsigned HIST_BITS = 8;
    localparam int unsigned CHO_BITS  = 8;

    // Mode code 3 is unused by the design; it must act as hybrid
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int unsigned HOT_COUNT     = 8;
    localparam int unsigned PHASE_WORDS   = 265;
    localparam int unsigned SETTLE_CYCLES = 8;
    // Must outlast the clearing pass after reset; every other quiet stretch is far shorter
    localparam int unsigned STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              taken;
    } branch_word_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_data;

    tbp_in_if  br_if ();
    tbp_out_if res_if ();

    tournament_branch_predictor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_br       (br_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor model state: its own copy of the tables, history, miss count
    // and mode. Updated in acceptance order, one step per input word.
    // ------------------------------------------------------------------------
    t_ctr                  bim_table [1 << BIM_BITS];
    t_ctr                  gsh_table [1 << GSH_BITS];
    t_ctr                  cho_table [1 << CHO_BITS];
    logic [HIST_BITS-1:0]  ghist;
    logic [TOTAL_W-1:0]    miss_total;
    logic [1:0]            active_mode;

    branch_word_t branch_queue [$];       // words waiting to be driven
    t_result      predicted_results [$];  // expected result words, oldest first

    int unsigned error_count;

    // Hot branch set: a handful of recurring branches with simple behaviors,
    // so the tables actually train and the chooser gets to move.
    logic [ADDR_W-1:0] hot_addr   [HOT_COUNT];
    int unsigned       hot_kind   [HOT_COUNT];
    int unsigned       hot_period [HOT_COUNT];
    int unsigned       hot_iter   [HOT_COUNT];

    function automatic t_ctr step_counter(t_ctr c, logic up);
        if (up)
            return (c == 2'd3) ? c : c + 2'd1;
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // One resolved branch: predict from the current state, then train.
    function automatic t_result resolve_branch(logic [ADDR_W-1:0] pc, logic outcome);
        logic [BIM_BITS-1:0] bi;
        logic [GSH_BITS-1:0] gi;
        logic [CHO_BITS-1:0] ci;
        logic                bim_says;
        logic                gsh_says;
        logic                pick_gshare;
        t_ctr                c;
        t_result             r;
        bi = pc[ADDR_LSB +: BIM_BITS];
        ci = pc[ADDR_LSB +: CHO_BITS];
        // History is no longer than the index here: it lands on the top bits
        gi = pc[ADDR_LSB +: GSH_BITS] ^ (GSH_BITS'(ghist) << (GSH_BITS - HIST_BITS));
        bim_says = bim_table[bi][1];
        gsh_says = gsh_table[gi][1];
        case (active_mode)
            MODE_BIMODAL: pick_gshare = 1'b0;
            MODE_GSHARE:  pick_gshare = 1'b1;
            default:      pick_gshare = cho_table[ci][1];
        endcase
        r.predicted_taken = pick_gshare ? gsh_says : bim_says;
        r.mispredicted    = r.predicted_taken != outcome;
        r.used_gshare     = pick_gshare;
        // Only the component that made the call is trained
        if (pick_gshare)
            gsh_table[gi] = step_counter(gsh_table[gi], outcome);
        else
            bim_table[bi] = step_counter(bim_table[bi], outcome);
        // Chooser leans toward whichever component alone was right
        if (active_mode[1]) begin
            c = cho_table[ci];
            if (bim_says == outcome && gsh_says != outcome)
                c = step_counter(c, 1'b0);
            else if (bim_says != outcome && gsh_says == outcome)
                c = step_counter(c, 1'b1);
            cho_table[ci] = c;
        end
        ghist = {outcome, ghist[HIST_BITS-1:1]};
        if (r.mispredicted && miss_total != '1)
            miss_total = miss_total + 1'b1;
        r.mispredict_total = miss_total;
        return r;
    endfunction

    function automatic logic hot_outcome(int unsigned h);
        logic t;
        case (hot_kind[h])
            0:       t = 1'b1;
            1:       t = 1'b0;
            2:       t = (hot_iter[h] % hot_period[h]) != hot_period[h] - 1; // loop exit
            3:       t = hot_iter[h][0];
            default: t = $urandom_range(0, 3) != 0;
        endcase
        hot_iter[h]++;
        return t;
    endfunction

    function automatic void reseed_hot(int unsigned keep);
        for (int unsigned h = keep; h < HOT_COUNT; h++) begin
            hot_addr[h]   = $urandom;
            hot_kind[h]   = $urandom_range(0, 4);
            hot_period[h] = $urandom_range(2, 9);
            hot_iter[h]   = 0;
        end
        // Force an alias: same low index bits as another hot branch
        hot_addr[HOT_COUNT-1][ADDR_LSB +: BIM_BITS] = hot_addr[0][ADDR_LSB +: BIM_BITS];
    endfunction

    function automatic void queue_word(logic [ADDR_W-1:0] a, logic t);
        branch_word_t w;
        w.address = a;
        w.taken   = t;
        branch_queue.push_back(w);
    endfunction

    task automatic report_mismatch(string field, logic [TOTAL_W-1:0] want,
                                   logic [TOTAL_W-1:0] got);
        $display("MISMATCH %0t: %s expected %0h got %0h", $realtime, field, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of back-to-back words with random gaps. valid holds until
    // the word is taken; the model steps on the acceptance edge.
    // ------------------------------------------------------------------------
    int unsigned  burst_left;
    int unsigned  gap_left;
    branch_word_t next_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            br_if.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (br_if.valid && br_if.ready)
                predicted_results.push_back(resolve_branch(br_if.branch_address, br_if.taken));
            if (!br_if.valid || br_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    br_if.valid <= 1'b0;
                end else if (branch_queue.size() > 0) begin
                    next_word = branch_queue.pop_front();
                    br_if.valid          <= 1'b1;
                    br_if.branch_address <= next_word.address;
                    br_if.taken          <= next_word.taken;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // New burst; a quarter of the time no gap at all
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    br_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result word against the oldest
    // expectation. Ready follows a stall style, redrawn each time style_cycles wraps.
    // ------------------------------------------------------------------------
    int unsigned stall_style;
    int unsigned style_cycles;
    t_result     want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_style  = 0;
            style_cycles = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (predicted_results.size() == 0) begin
                    // result word with nothing expected
                    report_mismatch("unexpected word", TOTAL_W'(0), res_if.mispredict_total);
                end else begin
                    want = predicted_results.pop_front();
                    if (res_if.predicted_taken !== want.predicted_taken)
                        report_mismatch("predicted_taken", want.predicted_taken,
                                        res_if.predicted_taken);
                    if (res_if.mispredicted !== want.mispredicted)
                        report_mismatch("mispredicted", want.mispredicted,
                                        res_if.mispredicted);
                    if (res_if.used_gshare !== want.used_gshare)
                        report_mismatch("used_gshare", want.used_gshare, res_if.used_gshare);
                    if (res_if.mispredict_total !== want.mispredict_total)
                        report_mismatch("mispredict_total", want.mispredict_total,
                                        res_if.mispredict_total);
                end
            end
            style_cycles++;
            if (style_cycles == 97) begin
                style_cycles = 0;
                stall_style  = $urandom_range(0, 3);
            end
            case (stall_style)
                0:       res_if.ready <= 1'b1;                          // no back-pressure
                1:       res_if.ready <= $urandom_range(0, 3) != 0;     // light
                2:       res_if.ready <= $urandom_range(0, 2) == 0;     // heavy
                default: res_if.ready <= (style_cycles % 8) < 5;        // square wave
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if nothing moves on either channel for too long
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((br_if.valid && br_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("TIMEOUT %0t: no word accepted in %0d cycles", $realtime, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------

    // Block is idle once every queued word went in and every result came out;
    // a settling wait then lets any stray word surface before the mode changes.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (branch_queue.size() != 0 || br_if.valid || predicted_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        active_mode = m;
        @(negedge i_clk);
    endtask

    logic [1:0] phase_modes [7] = '{MODE_BIMODAL, MODE_GSHARE, MODE_SPARE, MODE_HYBRID,
                                    MODE_GSHARE, MODE_BIMODAL, MODE_HYBRID};

    initial begin
        int unsigned       n;
        int unsigned       h;
        int unsigned       run;
        logic [ADDR_W-1:0] edge_addrs [8];

        // Known values on every input from time zero
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_data           = 2'd0;
        br_if.valid          = 1'b0;
        br_if.branch_address = '0;
        br_if.taken          = 1'b0;
        res_if.ready         = 1'b0;
        error_count          = 0;

        foreach (bim_table[i]) bim_table[i] = CTR_RESET;
        foreach (gsh_table[i]) gsh_table[i] = CTR_RESET;
        foreach (cho_table[i]) cho_table[i] = CHO_RESET;
        ghist       = '0;
        miss_total  = '0;
        active_mode = MODE_HYBRID;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words, in the reset mode (hybrid). Extremes of the address,
        // the ignored low bits, index-boundary addresses, an aliasing pair,
        // and a repeated branch that trains up then down so the two
        // components disagree and the chooser moves.
        edge_addrs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0003, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'h0000_0FFC, 32'h1000_0FFC, 32'h0000_0400};
        foreach (edge_addrs[i])
            queue_word(edge_addrs[i], i[0]);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        repeat (6) queue_word(32'h0000_0040, 1'b1);
        repeat (5) queue_word(32'h0000_0040, 1'b0);
        queue_word(32'h8000_0040, 1'b1);
        queue_word(32'h0000_0040, 1'b1);
        queue_word(32'h0000_0041, 1'b0);
        wait_idle();

        // Random phases, one per mode setting. Mostly runs of hot branches
        // with structured outcomes; the rest is random address / outcome noise.
        reseed_hot(0);
        foreach (phase_modes[p]) begin
            write_mode(phase_modes[p]);
            reseed_hot(HOT_COUNT / 2);
            n = 0;
            while (n < PHASE_WORDS) begin
                if ($urandom_range(0, 9) < 8) begin
                    h   = $urandom_range(0, HOT_COUNT - 1);
                    run = $urandom_range(1, 8);
                    repeat (run) queue_word(hot_addr[h], hot_outcome(h));
                    n += run;
                end else begin
                    queue_word($urandom, 1'($urandom_range(0, 1)));
                    n++;
                end
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tbp_pkg.sv
hw/rtl/tbp_in_if.sv
hw/rtl/tbp_out_if.sv
hw/rtl/tbp_ram.sv
hw/rtl/tbp_out_queue.sv
hw/rtl/tournament_branch_predictor.sv
verif/tournament_branch_predictor_test.sv
